// ===== rtl/line_pixel_rasterizer_macros.svh =====
// assertion macros used by the line pixel rasterizer back end
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LPR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lpr_pkg.sv =====
// shared constants and types of the line pixel rasterizer
package lpr_pkg;

    // default geometry
    localparam int COORD_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    // frame buffer addressing
    localparam int BPR_BITS       = 6;
    localparam logic [BPR_BITS-1:0] BPR_RESET = 6'd20;
    localparam int ADDR_BITS      = 13;
    localparam int BIT_BITS       = 3;
    localparam int PIX_BYTE_SHIFT = 3;
    localparam logic [BIT_BITS-1:0] BIT_INDEX_MAX = 3'd7;

    // request command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // classified request control bits
    typedef struct packed {
        logic is_start;
        logic major_is_x;
        logic neg;
        logic mode;
    } t_cmd_ctrl;

endpackage

// ===== rtl/lpr_front.sv =====
// front end: accepts requests, classifies them and precomputes line setup
module lpr_front #(
    parameter int COORD_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_command,
    input  logic [COORD_BITS-1:0]   i_x_start,
    input  logic [COORD_BITS-1:0]   i_y_start,
    input  logic [COORD_BITS-1:0]   i_x_end,
    input  logic [COORD_BITS-1:0]   i_y_end,
    input  logic                    i_set_mode,
    input  logic                    i_full,
    output logic                    o_push,
    output lpr_pkg::t_cmd_ctrl      o_ctrl,
    output logic [COORD_BITS-1:0]   o_anchor_minor,
    output logic [COORD_BITS-1:0]   o_first,
    output logic [COORD_BITS-1:0]   o_last,
    output logic signed [COORD_BITS:0] o_off,
    output logic [COORD_BITS-1:0]   o_nmag,
    output logic [COORD_BITS-1:0]   o_dmag
);
    import lpr_pkg::*;

    logic                   r_valid;
    t_cmd_ctrl              r_ctrl;
    logic [COORD_BITS-1:0]  r_anchor_minor;
    logic [COORD_BITS-1:0]  r_first;
    logic [COORD_BITS-1:0]  r_last;
    logic signed [COORD_BITS:0] r_off;
    logic [COORD_BITS-1:0]  r_nmag;
    logic [COORD_BITS-1:0]  r_dmag;

    logic [COORD_BITS-1:0]  w_dx, w_dy;
    logic                   w_major_is_x;
    logic [COORD_BITS-1:0]  w_maj0, w_maj1, w_min0, w_min1;
    logic [COORD_BITS-1:0]  w_nmag, w_dmag, w_first, w_last;
    logic signed [COORD_BITS:0] w_off;
    logic                   w_neg;
    logic                   w_accept;

    // endpoint deltas and major axis
    always_comb begin
        w_dx = (i_x_start >= i_x_end) ? i_x_start - i_x_end : i_x_end - i_x_start;
        w_dy = (i_y_start >= i_y_end) ? i_y_start - i_y_end : i_y_end - i_y_start;
        w_major_is_x = (w_dy <= w_dx);
        w_maj0 = w_major_is_x ? i_x_start : i_y_start;
        w_maj1 = w_major_is_x ? i_x_end   : i_y_end;
        w_min0 = w_major_is_x ? i_y_start : i_x_start;
        w_min1 = w_major_is_x ? i_y_end   : i_x_end;
        w_nmag = w_major_is_x ? w_dy : w_dx;
        w_dmag = w_major_is_x ? w_dx : w_dy;
        w_first = (w_maj0 < w_maj1) ? w_maj0 : w_maj1;
        w_last  = (w_maj0 < w_maj1) ? w_maj1 : w_maj0;
        // offset of the first major coordinate from the anchor, zero or negative
        w_off = $signed({1'b0, w_first}) - $signed({1'b0, w_maj0});
        w_neg = ((w_min1 < w_min0) != (w_maj1 < w_maj0)) && (w_nmag != '0);
    end

    // handshake with the queue
    assign o_stall  = r_valid && i_full;
    assign o_push   = r_valid && !i_full;
    assign w_accept = i_valid && !o_stall;

    // request valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // classified payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctrl.is_start   <= (i_command == CMD_START);
            r_ctrl.major_is_x <= w_major_is_x;
            r_ctrl.neg        <= w_neg;
            r_ctrl.mode       <= i_set_mode;
            r_anchor_minor    <= w_min0;
            r_first           <= w_first;
            r_last            <= w_last;
            r_off             <= w_off;
            r_nmag            <= w_nmag;
            r_dmag            <= w_dmag;
        end
    end

    assign o_ctrl         = r_ctrl;
    assign o_anchor_minor = r_anchor_minor;
    assign o_first        = r_first;
    assign o_last         = r_last;
    assign o_off          = r_off;
    assign o_nmag         = r_nmag;
    assign o_dmag         = r_dmag;

endmodule

// ===== rtl/lpr_queue.sv =====
// small register fifo between the front end and the back end
module lpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/lpr_back.sv =====
// back end: slope division, pixel stepping and address output stage
`include "line_pixel_rasterizer_macros.svh"

module lpr_back #(
    parameter int COORD_BITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lpr_pkg::BPR_BITS-1:0]      i_bpr,
    input  logic                              i_q_valid,
    output logic                              o_q_pop,
    input  lpr_pkg::t_cmd_ctrl                i_q_ctrl,
    input  logic [COORD_BITS-1:0]             i_q_anchor_minor,
    input  logic [COORD_BITS-1:0]             i_q_first,
    input  logic [COORD_BITS-1:0]             i_q_last,
    input  logic signed [COORD_BITS:0]        i_q_off,
    input  logic [COORD_BITS-1:0]             i_q_nmag,
    input  logic [COORD_BITS-1:0]             i_q_dmag,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [COORD_BITS-1:0]             o_pixel_x,
    output logic [COORD_BITS-1:0]             o_pixel_y,
    output logic [lpr_pkg::ADDR_BITS-1:0]     o_byte_address,
    output logic [lpr_pkg::BIT_BITS-1:0]      o_bit_index,
    output logic                              o_pixel_on,
    output logic                              o_last_pixel
);
    import lpr_pkg::*;

    localparam int Q_W    = FRAC_BITS + 1;
    localparam int SL_W   = FRAC_BITS + 2;
    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 2;
    localparam int PROD_W = SL_W + COORD_BITS + 1;
    localparam int REM_W  = COORD_BITS + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS + 1);
    localparam int PA_W   = COORD_BITS + BPR_BITS;
    localparam int SUM_W  = (PA_W + 1 > ADDR_BITS) ? PA_W + 1 : ADDR_BITS;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [REM_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_q;
    logic [COORD_BITS-1:0]   r_dmag;
    logic                    r_neg;
    logic                    r_major_is_x;
    logic                    r_mode;
    logic [COORD_BITS-1:0]   r_anchor_minor;
    logic [COORD_BITS-1:0]   r_cur;
    logic [COORD_BITS-1:0]   r_last;
    logic signed [COORD_BITS:0] r_off;
    logic signed [SL_W-1:0]  r_slope;
    logic signed [ACC_W-1:0] r_acc;

    logic                    r_a_valid;
    logic [COORD_BITS-1:0]   r_a_x, r_a_y;
    logic                    r_a_mode, r_a_last;

    logic                    r_o_valid;
    logic [COORD_BITS-1:0]   r_o_x, r_o_y;
    logic [ADDR_BITS-1:0]    r_o_addr;
    logic [BIT_BITS-1:0]     r_o_bit;
    logic                    r_o_mode, r_o_last;

    logic                    w_o_free, w_a_free;
    logic                    w_head_start, w_load, w_emit, w_drop;
    logic                    w_ge;
    logic [REM_W-1:0]        w_rem_sub;
    logic [Q_W-1:0]          w_q_fix;
    logic signed [SL_W-1:0]  w_slope;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0] w_minor_ofs;
    logic [COORD_BITS-1:0]   w_minor;
    logic                    w_last;
    logic [PA_W-1:0]         w_row_addr;
    logic [SUM_W-1:0]        w_addr_sum;

    // pipeline advance
    assign w_o_free = !r_o_valid || !i_stall;
    assign w_a_free = !r_a_valid || w_o_free;

    // queue head decode
    assign w_head_start = i_q_ctrl.is_start;
    assign w_load = i_q_valid && w_head_start && (r_state == ST_IDLE || r_state == ST_RUN);
    assign w_emit = i_q_valid && !w_head_start && (r_state == ST_RUN) && w_a_free;
    assign w_drop = i_q_valid && !w_head_start && (r_state == ST_IDLE);
    assign o_q_pop = w_load || w_emit || w_drop;

    // one restoring division step
    assign w_ge      = (r_rem >= {1'b0, r_dmag});
    assign w_rem_sub = w_ge ? r_rem - {1'b0, r_dmag} : r_rem;

    // signed slope and product for the first offset
    always_comb begin
        w_q_fix = (r_dmag == '0) ? '0 : r_q;
        w_slope = r_neg ? -$signed({1'b0, w_q_fix}) : $signed({1'b0, w_q_fix});
        w_prod  = w_slope * r_off;
    end

    // minor coordinate of the current pixel
    always_comb begin
        w_minor_ofs = r_acc >>> FRAC_BITS;
        w_minor     = r_anchor_minor + w_minor_ofs[COORD_BITS-1:0];
        w_last      = (r_cur >= r_last);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_load) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(FRAC_BITS)) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_load) begin
                    n_state = ST_DIV;
                end else if (w_emit && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_cnt <= '0;
            end else if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_a_free) begin
                r_a_valid <= w_emit;
            end
            if (w_o_free) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    // line setup, division and stepping
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem          <= {1'b0, i_q_nmag};
            r_dmag         <= i_q_dmag;
            r_neg          <= i_q_ctrl.neg;
            r_major_is_x   <= i_q_ctrl.major_is_x;
            r_mode         <= i_q_ctrl.mode;
            r_anchor_minor <= i_q_anchor_minor;
            r_cur          <= i_q_first;
            r_last         <= i_q_last;
            r_off          <= i_q_off;
        end else if (r_state == ST_DIV) begin
            r_rem <= {w_rem_sub[REM_W-2:0], 1'b0};
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end else if (r_state == ST_MUL) begin
            r_slope <= w_slope;
            r_acc   <= w_prod[ACC_W-1:0];
        end else if (w_emit && !w_last) begin
            r_cur <= r_cur + COORD_BITS'(1);
            r_acc <= r_acc + {{(ACC_W - SL_W){r_slope[SL_W-1]}}, r_slope};
        end
    end

    // pixel stage
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_a_x    <= r_major_is_x ? r_cur : w_minor;
            r_a_y    <= r_major_is_x ? w_minor : r_cur;
            r_a_mode <= r_mode;
            r_a_last <= w_last;
        end
    end

    // frame buffer address
    always_comb begin
        w_row_addr = PA_W'(r_a_y) * PA_W'(i_bpr);
        w_addr_sum = SUM_W'(w_row_addr) + SUM_W'(r_a_x >> PIX_BYTE_SHIFT);
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (w_o_free && r_a_valid) begin
            r_o_x    <= r_a_x;
            r_o_y    <= r_a_y;
            r_o_addr <= w_addr_sum[ADDR_BITS-1:0];
            r_o_bit  <= BIT_INDEX_MAX - r_a_x[BIT_BITS-1:0];
            r_o_mode <= r_a_mode;
            r_o_last <= r_a_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_pixel_x      = r_o_x;
    assign o_pixel_y      = r_o_y;
    assign o_byte_address = r_o_addr;
    assign o_bit_index    = r_o_bit;
    assign o_pixel_on     = r_o_mode;
    assign o_last_pixel   = r_o_last;

    // checks
    `LPR_ASSERT_IMPL(a_no_pop_busy, (r_state == ST_DIV || r_state == ST_MUL), !o_q_pop, "queue popped during slope setup")
    `LPR_ASSERT_IMPL(a_emit_run, w_emit, (r_state == ST_RUN), "pixel emitted outside run state")
    `LPR_ASSERT_NEXT(a_last_idle, (w_emit && w_last), (r_state == ST_IDLE), "line still active after last pixel")
    `LPR_ASSERT_IMPL(a_cnt_bound, (r_state == ST_DIV), (r_cnt <= CNT_W'(FRAC_BITS)), "division count overrun")
    `LPR_ASSERT_NEXT(a_mul_run, (r_state == ST_MUL), (r_state == ST_RUN), "multiply state did not enter run")

endmodule

// ===== rtl/line_pixel_rasterizer.sv =====
// line pixel rasterizer top level: config register, front end, queue, back end
// a tick request passes the front end register, the queue, the pixel and output stages;
// pixels follow at one per cycle while ticks arrive and i_stall is low, stepped by the
// slope accumulator in the back end; a start request holds the back end in the restoring
// slope divider, one quotient bit per cycle, then in a multiply step for the first offset
// reset is synchronous and active low: no line active, bytes per row back to 20
module line_pixel_rasterizer #(
    parameter int COORD_BITS = lpr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = lpr_pkg::FRAC_BITS_DEF,
    parameter int Q_DEPTH    = lpr_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lpr_pkg::BPR_BITS-1:0]   i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_command,
    input  logic [COORD_BITS-1:0]          i_x_start,
    input  logic [COORD_BITS-1:0]          i_y_start,
    input  logic [COORD_BITS-1:0]          i_x_end,
    input  logic [COORD_BITS-1:0]          i_y_end,
    input  logic                           i_set_mode,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [COORD_BITS-1:0]          o_pixel_x,
    output logic [COORD_BITS-1:0]          o_pixel_y,
    output logic [lpr_pkg::ADDR_BITS-1:0]  o_byte_address,
    output logic [lpr_pkg::BIT_BITS-1:0]   o_bit_index,
    output logic                           o_pixel_on,
    output logic                           o_last_pixel
);
    import lpr_pkg::*;

    localparam int QW = $bits(t_cmd_ctrl) + 5 * COORD_BITS + COORD_BITS + 1;

    logic [BPR_BITS-1:0]        r_bytes_per_row;

    logic                       f_push;
    t_cmd_ctrl                  f_ctrl;
    logic [COORD_BITS-1:0]      f_anchor_minor, f_first, f_last, f_nmag, f_dmag;
    logic signed [COORD_BITS:0] f_off;

    logic                       q_full, q_valid, q_pop;
    logic [QW-1:0]              q_wdata, q_rdata;
    t_cmd_ctrl                  q_ctrl;
    logic [COORD_BITS-1:0]      q_anchor_minor, q_first, q_last, q_nmag, q_dmag;
    logic signed [COORD_BITS:0] q_off;

    // bytes per row register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_row <= BPR_RESET;
        end else if (i_cfg_we) begin
            r_bytes_per_row <= i_cfg_data;
        end
    end

    // front end
    lpr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_set_mode     (i_set_mode),
        .i_full         (q_full),
        .o_push         (f_push),
        .o_ctrl         (f_ctrl),
        .o_anchor_minor (f_anchor_minor),
        .o_first        (f_first),
        .o_last         (f_last),
        .o_off          (f_off),
        .o_nmag         (f_nmag),
        .o_dmag         (f_dmag)
    );

    // queue entry packing
    assign q_wdata = {f_ctrl, f_anchor_minor, f_first, f_last, f_off, f_nmag, f_dmag};
    assign {q_ctrl, q_anchor_minor, q_first, q_last, q_off, q_nmag, q_dmag} = q_rdata;

    lpr_queue #(
        .WIDTH (QW),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_rdata)
    );

    // back end
    lpr_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_bpr            (r_bytes_per_row),
        .i_q_valid        (q_valid),
        .o_q_pop          (q_pop),
        .i_q_ctrl         (q_ctrl),
        .i_q_anchor_minor (q_anchor_minor),
        .i_q_first        (q_first),
        .i_q_last         (q_last),
        .i_q_off          (q_off),
        .i_q_nmag         (q_nmag),
        .i_q_dmag         (q_dmag),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_byte_address   (o_byte_address),
        .o_bit_index      (o_bit_index),
        .o_pixel_on       (o_pixel_on),
        .o_last_pixel     (o_last_pixel)
    );

endmodule

// ===== test/line_pixel_rasterizer_test.sv =====
// self-checking testbench for the line pixel rasterizer with a predicting pixel checker
`timescale 1ns / 100ps

// one emitted pixel, as seen on the result port
typedef struct packed {
    logic [lpr_pkg::COORD_BITS_DEF-1:0] pixel_x;
    logic [lpr_pkg::COORD_BITS_DEF-1:0] pixel_y;
    logic [lpr_pkg::ADDR_BITS-1:0]      byte_address;
    logic [lpr_pkg::BIT_BITS-1:0]       bit_index;
    logic                               pixel_on;
    logic                               last_pixel;
} t_pixel;

// tracks the line in progress and the pixels still owed by the block
class line_pixel_checker;
    localparam int CW = lpr_pkg::COORD_BITS_DEF;
    localparam int FB = lpr_pkg::FRAC_BITS_DEF;

    logic [lpr_pkg::BPR_BITS-1:0] row_bytes;
    logic                         line_active;
    logic                         major_is_x;
    logic                         draw_mode;
    logic [CW-1:0]                major_pos;
    logic [CW-1:0]                major_stop;
    logic [CW-1:0]                anchor_major;
    logic [CW-1:0]                anchor_minor;
    longint                       slope_q;
    t_pixel                       pixels_due[$];
    int                           mismatches;
    int                           pixels_checked;
    int                           lines_started;
    int                           idle_ticks;

    function new();
        row_bytes      = lpr_pkg::BPR_RESET;
        line_active    = 1'b0;
        major_is_x     = 1'b0;
        draw_mode      = 1'b0;
        major_pos      = '0;
        major_stop     = '0;
        anchor_major   = '0;
        anchor_minor   = '0;
        slope_q        = 0;
        mismatches     = 0;
        pixels_checked = 0;
        lines_started  = 0;
        idle_ticks     = 0;
    endfunction

    function int span(logic [CW-1:0] a, logic [CW-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function int pending();
        return pixels_due.size();
    endfunction

    // accepted request: a start loads a line, a tick predicts one pixel
    // returns 0 for a tick that the block ignores
    function bit note_request(logic cmd, logic [CW-1:0] x1, logic [CW-1:0] y1,
                              logic [CW-1:0] x2, logic [CW-1:0] y2, logic mode);
        logic [CW-1:0] maj0, maj1, min0, min1;
        logic [CW-1:0] minor;
        longint        num, den, prod, minor_full;
        int            addr;
        t_pixel        pix;
        if (cmd == lpr_pkg::CMD_START) begin
            draw_mode  = mode;
            major_is_x = span(y1, y2) <= span(x1, x2);
            if (major_is_x) begin
                maj0 = x1; maj1 = x2; min0 = y1; min1 = y2;
            end else begin
                maj0 = y1; maj1 = y2; min0 = x1; min1 = x2;
            end
            anchor_major = maj0;
            anchor_minor = min0;
            den = span(maj0, maj1);
            num = span(min0, min1);
            // quotient magnitude first, sign applied after: truncates toward zero
            slope_q = (den == 0) ? 0 : (num << FB) / den;
            if ((min1 < min0) != (maj1 < maj0))
                slope_q = -slope_q;
            major_pos   = (maj0 < maj1) ? maj0 : maj1;
            major_stop  = (maj0 < maj1) ? maj1 : maj0;
            line_active = 1'b1;
            lines_started++;
            return 1'b1;
        end
        if (!line_active) begin
            idle_ticks++;
            return 1'b0;
        end
        // arithmetic shift floors the scaled product
        prod       = slope_q * (longint'(major_pos) - longint'(anchor_major));
        minor_full = longint'(anchor_minor) + (prod >>> FB);
        minor      = minor_full[CW-1:0];
        pix.pixel_x      = major_is_x ? major_pos : minor;
        pix.pixel_y      = major_is_x ? minor : major_pos;
        addr             = int'(pix.pixel_y) * int'(row_bytes)
                         + int'(pix.pixel_x >> lpr_pkg::PIX_BYTE_SHIFT);
        pix.byte_address = addr[lpr_pkg::ADDR_BITS-1:0];
        pix.bit_index    = lpr_pkg::BIT_INDEX_MAX - pix.pixel_x[2:0];
        pix.pixel_on     = draw_mode;
        pix.last_pixel   = major_pos >= major_stop;
        pixels_due.push_back(pix);
        if (pix.last_pixel)
            line_active = 1'b0;
        else
            major_pos = major_pos + 1'b1;
        return 1'b1;
    endfunction

    // accepted result against the oldest predicted pixel
    function void check_pixel(t_pixel got);
        t_pixel want;
        if (pixels_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel x=%0d y=%0d addr=%0d bit=%0d on=%0b last=%0b",
                         got.pixel_x, got.pixel_y, got.byte_address, got.bit_index,
                         got.pixel_on, got.last_pixel);
            return;
        end
        want = pixels_due.pop_front();
        pixels_checked++;
        if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.byte_address !== want.byte_address || got.bit_index !== want.bit_index ||
            got.pixel_on !== want.pixel_on || got.last_pixel !== want.last_pixel) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("pixel %0d mismatch, row bytes %0d", pixels_checked, row_bytes);
                $display("  expected x=%0d y=%0d addr=%0d bit=%0d on=%0b last=%0b",
                         want.pixel_x, want.pixel_y, want.byte_address, want.bit_index,
                         want.pixel_on, want.last_pixel);
                $display("  actual   x=%0d y=%0d addr=%0d bit=%0d on=%0b last=%0b",
                         got.pixel_x, got.pixel_y, got.byte_address, got.bit_index,
                         got.pixel_on, got.last_pixel);
            end
        end
    endfunction
endclass

module line_pixel_rasterizer_test;
    import lpr_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int SETTLE      = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 105;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [BPR_BITS-1:0]  i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_command;
    logic [CW-1:0]        i_x_start;
    logic [CW-1:0]        i_y_start;
    logic [CW-1:0]        i_x_end;
    logic [CW-1:0]        i_y_end;
    logic                 i_set_mode;
    logic                 o_valid;
    logic                 i_stall;
    logic [CW-1:0]        o_pixel_x;
    logic [CW-1:0]        o_pixel_y;
    logic [ADDR_BITS-1:0] o_byte_address;
    logic [BIT_BITS-1:0]  o_bit_index;
    logic                 o_pixel_on;
    logic                 o_last_pixel;

    line_pixel_checker scoreboard = new();
    bit                idle_en;
    int                items_sent;
    int                cycle_count;
    int                random_row;

    line_pixel_rasterizer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_x_start      (i_x_start),
        .i_y_start      (i_y_start),
        .i_x_end        (i_x_end),
        .i_y_end        (i_y_end),
        .i_set_mode     (i_set_mode),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_byte_address (o_byte_address),
        .o_bit_index    (o_bit_index),
        .o_pixel_on     (o_pixel_on),
        .o_last_pixel   (o_last_pixel)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still due",
                     cycle_count, scoreboard.pending());
            $display("** line_pixel_rasterizer: FAILED **");
            $finish;
        end
    end

    // gap length before a request: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // result side: check accepted pixels, then pick the next stall level
    initial begin : result_side
        int stall_left;
        int free_left;
        int r;
        stall_left = 0;
        free_left  = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                scoreboard.check_pixel('{o_pixel_x, o_pixel_y, o_byte_address, o_bit_index,
                                         o_pixel_on, o_last_pixel});
            if (!idle_en) begin
                stall_left = 0;
                free_left  = 0;
            end else if (stall_left == 0 && free_left == 0) begin
                free_left  = $urandom_range(12, 0);
                r          = $urandom_range(99, 0);
                stall_left = (r < 85) ? $urandom_range(3, 1) : $urandom_range(30, 8);
            end
            if (!idle_en || free_left > 0) begin
                i_stall <= 1'b0;
                if (free_left > 0)
                    free_left--;
            end else begin
                i_stall <= 1'b1;
                stall_left--;
            end
        end
    end

    // one request through the valid/stall handshake
    task automatic send_request(input logic cmd, input logic [CW-1:0] x1,
                                input logic [CW-1:0] y1, input logic [CW-1:0] x2,
                                input logic [CW-1:0] y2, input logic mode);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_x_start  <= x1;
        i_y_start  <= y1;
        i_x_end    <= x2;
        i_y_end    <= y2;
        i_set_mode <= mode;
        do @(posedge i_clk); while (o_stall);
        if (scoreboard.note_request(cmd, x1, y1, x2, y2, mode))
            items_sent++;
    endtask

    // tick with random don't-care payload
    task automatic send_tick();
        send_request(CMD_TICK, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
                     1'($urandom));
    endtask

    // drop valid, let every pixel arrive, then let a pending division finish
    task automatic drain();
        i_valid <= 1'b0;
        while (scoreboard.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // bytes per row write while the block is idle
    task automatic write_row_bytes(input logic [BPR_BITS-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scoreboard.row_bytes = value;
    endtask

    // random line: mostly short, a few long; usually drawn to the end,
    // sometimes cut short by the next start or followed by idle ticks
    task automatic random_line();
        int dmaj, dmin, r, lo, n;
        logic [CW-1:0] a0, a1, b0, b1, t;
        r = $urandom_range(99, 0);
        if (r < 85)
            dmaj = $urandom_range(8, 0);
        else if (r < 97)
            dmaj = $urandom_range(40, 9);
        else
            dmaj = $urandom_range(255, 41);
        r = $urandom_range(99, 0);
        if (r < 15)
            dmin = dmaj;
        else if (r < 25)
            dmin = 0;
        else
            dmin = $urandom_range(dmaj, 0);
        lo = $urandom_range(255 - dmaj, 0);
        a0 = CW'(lo);
        a1 = CW'(lo + dmaj);
        if ($urandom_range(1, 0)) begin
            t = a0; a0 = a1; a1 = t;
        end
        lo = $urandom_range(255 - dmin, 0);
        b0 = CW'(lo);
        b1 = CW'(lo + dmin);
        if ($urandom_range(1, 0)) begin
            t = b0; b0 = b1; b1 = t;
        end
        if ($urandom_range(1, 0))
            send_request(CMD_START, a0, b0, a1, b1, 1'($urandom));
        else
            send_request(CMD_START, b0, a0, b1, a1, 1'($urandom));
        r = $urandom_range(99, 0);
        if (r < 12)
            n = $urandom_range(dmaj, 0);
        else if (r < 90)
            n = dmaj + 1;
        else
            n = dmaj + 1 + $urandom_range(3, 1);
        repeat (n) send_tick();
    endtask

    // stimulus
    initial begin : request_side
        logic [BPR_BITS-1:0] row_plan[6];
        idle_en     = 1'b1;
        items_sent  = 0;
        cycle_count = 0;
        random_row  = $urandom_range(62, 2);
        row_plan    = '{6'd1, 6'd32, 6'd0, 6'd63, random_row[BPR_BITS-1:0], BPR_RESET};
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_command  <= CMD_START;
        i_x_start  <= '0;
        i_y_start  <= '0;
        i_x_end    <= '0;
        i_y_end    <= '0;
        i_set_mode <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines at the reset row width
        // tick with no line loaded
        send_tick();
        // single-pixel lines at both corners
        send_request(CMD_START, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
        send_tick();
        send_request(CMD_START, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
        send_tick();
        // diagonal tie: x major, falling slope, drawn from the smaller x
        send_request(CMD_START, 8'd255, 8'd0, 8'd252, 8'd3, 1'b1);
        repeat (4) send_tick();
        // steep line abandoned after two pixels by a new start
        send_request(CMD_START, 8'd3, 8'd250, 8'd1, 8'd255, 1'b1);
        repeat (2) send_tick();
        send_request(CMD_START, 8'd8, 8'd1, 8'd15, 8'd3, 1'b0);
        repeat (8) send_tick();
        // one tick past the end of the line
        send_tick();

        // random lines over several row widths, one stretch without idling
        foreach (row_plan[p]) begin
            drain();
            idle_en = (p != 4);
            write_row_bytes(row_plan[p]);
            begin : phase_body
                int goal;
                goal = items_sent + PHASE_ITEMS;
                while (items_sent < goal) begin
                    if ($urandom_range(19, 0) == 0)
                        send_tick();
                    random_line();
                end
            end
        end
        idle_en = 1'b1;
        drain();

        $display("covered %0d requests: %0d lines started, %0d pixels checked, %0d idle ticks",
                 items_sent, scoreboard.lines_started, scoreboard.pixels_checked,
                 scoreboard.idle_ticks);
        $display("row widths 20, 1, 32, 0, 63 and %0d, with and without idling on both sides",
                 random_row);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
            $display("** line_pixel_rasterizer: PASSED **");
        end else begin
            $display("%0d mismatches, %0d pixels never arrived",
                     scoreboard.mismatches, scoreboard.pending());
            $display("** line_pixel_rasterizer: FAILED **");
        end
        $finish;
    end

endmodule

// ===== line_pixel_rasterizer.f =====
+incdir+rtl
rtl/lpr_pkg.sv
rtl/lpr_front.sv
rtl/lpr_queue.sv
rtl/lpr_back.sv
rtl/line_pixel_rasterizer.sv
test/line_pixel_rasterizer_test.sv
